[rtl/core/mtg_pkg.sv]
package mtg_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned SHIFT_OFFSET = 397;
  localparam int unsigned IDX_W        = 10;

  localparam logic [IDX_W-1:0] POS_USED  = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] POS_NEVER = IDX_W'(STATE_WORDS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] FAR_WRAP  = IDX_W'(STATE_WORDS - SHIFT_OFFSET);
  localparam logic [IDX_W-1:0] FAR_OFF   = IDX_W'(SHIFT_OFFSET);

  localparam logic [31:0] TWIST_XOR    = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;
  localparam logic [31:0] LCG_MUL      = 32'd69069;
  localparam logic [31:0] DEFAULT_SEED = 32'd4357;

  localparam logic [1:0] KIND_DRAW   = 2'd0;
  localparam logic [1:0] KIND_RESEED = 2'd1;
  localparam logic [1:0] KIND_LOAD   = 2'd2;

  typedef struct packed {
    logic             fill_start;
    logic             fill_default;
    logic             fill_step;
    logic             tw_prime;
    logic             tw_issue;
    logic             load_wr;
    logic             draw_rd;
    logic             out_load;
    logic [IDX_W-1:0] pos;
  } mtg_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic tw_last;
    logic out_free;
  } mtg_sts_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[rtl/core/mtg_datapath.sv]
module mtg_datapath import mtg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  mtg_cmd_t         cmd,
  input  logic [31:0]      seed_value,
  input  logic [IDX_W-1:0] load_index,
  input  logic [31:0]      load_value,
  output mtg_sts_t         sts,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata
);

  logic [31:0]      mem [STATE_WORDS];
  logic [31:0]      rd_a_r, rd_b_r, carry_r;
  logic [31:0]      lcg_r, lcg_nxt;
  logic [15:0]      hi_r;
  logic             phase_r;
  logic [IDX_W-1:0] idx_r, wk_r;
  logic             tw_v_r;
  logic [31:0]      out_word_r;
  logic             out_valid_r;

  logic [IDX_W-1:0] nxt_idx, far_idx, addr_a, waddr;
  logic             ren_a, we;
  logic [31:0]      wdata, twist_y, twist_v;

  assign lcg_nxt = lcg_r * LCG_MUL + 32'd1;
  assign nxt_idx = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
  assign far_idx = (idx_r >= FAR_WRAP) ? idx_r - FAR_WRAP : idx_r + FAR_OFF;

  assign ren_a = cmd.tw_prime | cmd.tw_issue | cmd.draw_rd;

  always_comb begin
    priority if (cmd.tw_prime) begin
      addr_a = '0;
    end else if (cmd.tw_issue) begin
      addr_a = nxt_idx;
    end else begin
      addr_a = cmd.pos;
    end
  end

  // carry_r holds the old word k, rd_a_r word k+1, rd_b_r the far word
  assign twist_y = {carry_r[31], rd_a_r[30:0]};
  assign twist_v = rd_b_r ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_XOR : 32'd0);

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = twist_v;
    priority if (tw_v_r) begin
      we    = 1'b1;
      waddr = wk_r;
    end else if (cmd.fill_step && phase_r) begin
      we    = 1'b1;
      wdata = {hi_r, lcg_r[31:16]};
    end else if (cmd.load_wr) begin
      we    = 1'b1;
      waddr = load_index;
      wdata = load_value;
    end else begin
      we    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren_a) begin
      rd_a_r <= mem[addr_a];
    end
    if (cmd.tw_issue) begin
      rd_b_r <= mem[far_idx];
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= rd_a_r;
    wk_r    <= idx_r;
    if (cmd.fill_start) begin
      lcg_r <= cmd.fill_default ? DEFAULT_SEED : seed_value;
    end else if (cmd.fill_step) begin
      lcg_r <= lcg_nxt;
    end
    if (cmd.fill_step && !phase_r) begin
      hi_r <= lcg_r[31:16];
    end
    if (cmd.out_load) begin
      out_word_r <= temper(rd_a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      phase_r     <= 1'b0;
      tw_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tw_v_r <= cmd.tw_issue;
      if (cmd.fill_start || cmd.tw_prime) begin
        idx_r <= '0;
      end else if ((cmd.fill_step && phase_r) || cmd.tw_issue) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.fill_start) begin
        phase_r <= 1'b0;
      end else if (cmd.fill_step) begin
        phase_r <= ~phase_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.fill_done = cmd.fill_step && phase_r && (idx_r == LAST_IDX);
  assign sts.tw_last   = (idx_r == LAST_IDX);
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;

endmodule

[rtl/core/mtg_ctrl.sv]
module mtg_ctrl import mtg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [1:0]       in_kind,
  input  logic [IDX_W-1:0] in_load_index,
  input  mtg_sts_t         sts,
  output mtg_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_TW_PRIME,
    S_TWIST,
    S_TW_DRAIN,
    S_READ,
    S_DELIVER
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             twist_after_r, twist_after_nxt;
  logic             accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    twist_after_nxt = twist_after_r;
    cmd             = '0;
    cmd.pos         = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_DRAW: begin
              if (pos_r == POS_NEVER) begin
                cmd.fill_start   = 1'b1;
                cmd.fill_default = 1'b1;
                twist_after_nxt  = 1'b1;
                state_nxt        = S_FILL;
              end else if (pos_r == POS_USED) begin
                state_nxt = S_TW_PRIME;
              end else begin
                cmd.draw_rd = 1'b1;
                pos_nxt     = pos_r + IDX_W'(1);
                state_nxt   = S_DELIVER;
              end
            end
            KIND_RESEED: begin
              cmd.fill_start  = 1'b1;
              twist_after_nxt = 1'b0;
              state_nxt       = S_FILL;
            end
            KIND_LOAD: begin
              // drop loads that point past the state array
              if (in_load_index < POS_USED) begin
                cmd.load_wr = 1'b1;
                pos_nxt     = POS_USED;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_done) begin
          pos_nxt   = POS_USED;
          state_nxt = twist_after_r ? S_TW_PRIME : S_IDLE;
        end
      end
      S_TW_PRIME: begin
        cmd.tw_prime = 1'b1;
        state_nxt    = S_TWIST;
      end
      S_TWIST: begin
        cmd.tw_issue = 1'b1;
        if (sts.tw_last) begin
          state_nxt = S_TW_DRAIN;
        end
      end
      S_TW_DRAIN: begin
        pos_nxt   = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.draw_rd = 1'b1;
        pos_nxt     = pos_r + IDX_W'(1);
        state_nxt   = S_DELIVER;
      end
      S_DELIVER: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pos_r         <= POS_NEVER;
      twist_after_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      twist_after_r <= twist_after_nxt;
    end
  end

endmodule

[rtl/core/mersenne_twister_generator.sv]
// MT19937 32-bit random word generator.
// Input stream (in_*): one beat per request. in_tuser carries the request
// kind (draw, reseed, load one state word); in_tdata carries the state word
// index and raw value used by a load. Only draws produce an output beat.
// Output stream (out_*): one tempered 32-bit word per draw.
// Config port (cfg_*): APB-style, one register, the 32-bit seed at address 0,
// used by reseed requests; reset value 4357.
// Sequencing: a draw from a live state reads its word from the state memory,
// then tempers it into the output register once that is free; no request is
// taken in between. Every 624th draw, and the first draw after a reseed or
// load, first regenerates the state, one word per cycle through the two read
// ports of the state memory. A reseed fills each word from two steps of the
// 69069 multiply loop. A load writes its state word without leaving idle. A
// draw without prior seeding runs the default seeding, then the regeneration.
// Reset: the generator returns to its never-seeded condition; the state
// memory itself is not cleared. While the output beat is stalled the block
// still takes reseed and load requests; a further draw waits until the
// pending word is taken.
module mersenne_twister_generator import mtg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // [9:0] load_index, [41:10] load_value, rest zero
  input  logic [1:0]  in_tuser,    // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] random_word
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_SEED = 1'b0;

  logic [31:0] seed_r;
  logic        cfg_wr;
  mtg_cmd_t    cmd;
  mtg_sts_t    sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_SEED) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= DEFAULT_SEED;
    end else if (cfg_wr && (cfg_paddr[2] == REG_SEED)) begin
      seed_r <= cfg_pwdata;
    end
  end

  mtg_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_kind       (in_tuser),
    .in_load_index (in_tdata[9:0]),
    .sts           (sts),
    .cmd           (cmd)
  );

  mtg_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .seed_value (seed_r),
    .load_index (in_tdata[9:0]),
    .load_value (in_tdata[41:10]),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[dv/mersenne_twister_generator_test.sv]
module mersenne_twister_generator_test import mtg_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] SEED_ADDR   = 3'd0;
  localparam logic [2:0] SPARE_ADDR  = 3'd4;
  localparam int SETTLE_CYCLES = 2500;

  typedef struct {
    logic [1:0]  kind;
    logic [9:0]  load_index;
    logic [31:0] load_value;
    bit          drain;
  } mt_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // [9:0] load_index, [41:10] load_value, rest zero
  logic [1:0]  in_tuser = '0;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;      // [31:0] random_word
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mersenne_twister_generator dut (.*);

  // Generator model
  logic [31:0] mt_words [STATE_WORDS];
  logic [9:0]  mt_pos = POS_NEVER;
  logic [31:0] mt_seed = DEFAULT_SEED;

  mt_req_t     pending_reqs[$];
  logic [31:0] expected_words[$];
  int beats_queued = 0;
  int beats_taken = 0;
  bit in_taken = 1'b0;
  int fail_count = 0;
  int draws_done = 0, reseeds_done = 0, loads_done = 0, ignored_done = 0, twists_done = 0;

  function automatic logic [31:0] temper_word(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    return y ^ (y >> 18);
  endfunction

  function automatic void seed_fill(input logic [31:0] s);
    logic [31:0] x, w;
    x = s;
    for (int i = 0; i < STATE_WORDS; i++) begin
      w = x & 32'hffff0000;
      x = x * LCG_MUL + 32'd1;
      w = w | ((x & 32'hffff0000) >> 16);
      x = x * LCG_MUL + 32'd1;
      mt_words[i] = w;
    end
    mt_pos = POS_USED;
  endfunction

  function automatic void twist_state();
    logic [31:0] y, v;
    for (int k = 0; k < STATE_WORDS; k++) begin
      y = (mt_words[k] & 32'h80000000) | (mt_words[(k + 1) % STATE_WORDS] & 32'h7fffffff);
      v = mt_words[(k + SHIFT_OFFSET) % STATE_WORDS] ^ (y >> 1);
      if (y[0]) v = v ^ TWIST_XOR;
      mt_words[k] = v;
    end
    mt_pos = '0;
    twists_done++;
  endfunction

  // Apply one request to the model; returns 1 when it yields a word.
  function automatic bit predict_request(input logic [1:0] kind, input logic [9:0] idx,
                                         input logic [31:0] val, output logic [31:0] word);
    word = '0;
    case (kind)
      KIND_DRAW: begin
        if (mt_pos >= POS_USED) begin
          // never seeded: default seed, not the register
          if (mt_pos == POS_NEVER) seed_fill(DEFAULT_SEED);
          twist_state();
        end
        word = temper_word(mt_words[mt_pos]);
        mt_pos = mt_pos + 10'd1;
        draws_done++;
        return 1'b1;
      end
      KIND_RESEED: begin
        seed_fill(mt_seed);
        reseeds_done++;
      end
      KIND_LOAD: begin
        if (idx < STATE_WORDS) begin
          mt_words[idx] = val;
          mt_pos = POS_USED;
          loads_done++;
        end else begin
          ignored_done++;
        end
      end
      default: ignored_done++;
    endcase
    return 1'b0;
  endfunction

  task automatic queue_req(input logic [1:0] kind, input logic [9:0] idx,
                           input logic [31:0] val, input bit drain = 1'b0);
    mt_req_t r;
    r.kind = kind;
    r.load_index = idx;
    r.load_value = val;
    r.drain = drain;
    pending_reqs.push_back(r);
    beats_queued++;
  endtask

  // Mixed traffic: mostly draws, loads forcing early twists, some reseeds and noise.
  task automatic queue_mixed();
    int roll;
    logic [9:0] idx;
    roll = $urandom_range(0, 99);
    idx = 10'($urandom_range(0, 1023));
    if (roll < 72) begin
      queue_req(KIND_DRAW, idx, $urandom(), ($urandom_range(0, 99) == 0));
    end else if (roll < 84) begin
      case ($urandom_range(0, 5))
        0: idx = 10'd0;
        1: idx = LAST_IDX;
        2: idx = FAR_OFF;
        default: idx = 10'($urandom_range(0, STATE_WORDS - 1));
      endcase
      queue_req(KIND_LOAD, idx, $urandom());
    end else if (roll < 89) begin
      queue_req(KIND_RESEED, idx, $urandom());
    end else if (roll < 94) begin
      queue_req(KIND_LOAD, 10'($urandom_range(STATE_WORDS, 1023)), $urandom());
    end else begin
      queue_req(KIND_UNUSED, idx, $urandom());
    end
  endtask

  task automatic cfg_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Hold until every queued beat is taken and every word has come back.
  task automatic wait_idle();
    while (beats_taken != beats_queued || expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Input driver: bursts of beats with random gaps.
  always @(negedge clk) begin : drive_in
    mt_req_t r;
    static int gap_left = 0;
    static int burst_left = 0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain && expected_words.size() != 0)) begin
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= r.kind;
        in_tdata <= {6'd0, r.load_value, r.load_index};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output backpressure: switch among four stall patterns, each held for a random span.
  always @(negedge clk) begin : drive_out_ready
    static int mode = 0;
    static int mode_left = 0;
    static int hold_left = 0;
    static int phase = 0;
    if (mode_left == 0) begin
      mode = $urandom_range(0, 3);
      mode_left = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    phase++;
    case (mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (phase % 4 == 0);
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 30);
        end
      end
    endcase
  end

  // Monitor: check returned words, predict on every accepted beat, track the seed.
  always @(posedge clk) begin : monitor
    logic [31:0] exp_word, new_word;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: random_word with none expected, expected nothing got %08h",
                   $realtime, out_tdata);
          fail_count++;
        end else begin
          exp_word = expected_words.pop_front();
          if (out_tdata !== exp_word) begin
            $display("%0t: random_word mismatch, expected %08h got %08h",
                     $realtime, exp_word, out_tdata);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        beats_taken++;
        if (predict_request(in_tuser, in_tdata[9:0], in_tdata[41:10], new_word))
          expected_words.push_back(new_word);
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr == SEED_ADDR) mt_seed = cfg_pwdata;
        end else if (cfg_paddr == SEED_ADDR && cfg_prdata !== mt_seed) begin
          $display("%0t: seed_value readback mismatch, expected %08h got %08h",
                   $realtime, mt_seed, cfg_prdata);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Seed register differs from the default so the unseeded first draw is visible.
    cfg_access(1'b1, SEED_ADDR, 32'd0);
    cfg_access(1'b0, SEED_ADDR, 32'd0);

    queue_req(KIND_UNUSED, 10'h3ff, 32'hffffffff);
    queue_req(KIND_LOAD, 10'h3ff, 32'hffffffff);
    queue_req(KIND_LOAD, 10'(STATE_WORDS), 32'd0);
    queue_req(KIND_DRAW, 10'd0, 32'd0);
    queue_req(KIND_DRAW, 10'h3ff, 32'hffffffff);
    queue_req(KIND_DRAW, 10'd0, 32'd0, 1'b1);
    queue_req(KIND_RESEED, 10'h3ff, 32'hffffffff);
    queue_req(KIND_DRAW, 10'd0, 32'd0);
    queue_req(KIND_LOAD, 10'd0, 32'd0);
    queue_req(KIND_LOAD, LAST_IDX, 32'hffffffff);
    queue_req(KIND_LOAD, FAR_OFF, 32'h80000000);
    queue_req(KIND_DRAW, 10'd0, 32'd0);
    queue_req(KIND_DRAW, 10'd0, 32'd0);
    queue_req(KIND_UNUSED, 10'd0, 32'd0);
    queue_req(KIND_DRAW, 10'd0, 32'd0, 1'b1);
    queue_req(KIND_LOAD, 10'd1, 32'h7fffffff);
    queue_req(KIND_RESEED, 10'd0, 32'd0);
    queue_req(KIND_LOAD, LAST_IDX, 32'd1);
    queue_req(KIND_DRAW, 10'd0, 32'd0);
    queue_req(KIND_DRAW, 10'd0, 32'd0);
    wait_idle();

    // Writes to the spare address must leave the seed alone.
    cfg_access(1'b1, SPARE_ADDR, 32'hffffffff);
    cfg_access(1'b0, SEED_ADDR, 32'd0);
    cfg_access(1'b1, SEED_ADDR, 32'hffffffff);
    cfg_access(1'b0, SEED_ADDR, 32'd0);

    // Long draw run from a fresh reseed: crosses the regeneration boundary twice.
    queue_req(KIND_RESEED, 10'($urandom_range(0, 1023)), $urandom());
    for (int n = 0; n < 700; n++) begin
      if ($urandom_range(0, 99) < 3)
        queue_req(KIND_UNUSED, 10'($urandom_range(0, 1023)), $urandom());
      else if ($urandom_range(0, 99) < 2)
        queue_req(KIND_LOAD, 10'($urandom_range(STATE_WORDS, 1023)), $urandom());
      else
        queue_req(KIND_DRAW, 10'($urandom_range(0, 1023)), $urandom(), (n == 350));
    end
    wait_idle();

    for (int p = 0; p < 2; p++) begin
      cfg_access(1'b1, SEED_ADDR, $urandom());
      cfg_access(1'b0, SEED_ADDR, 32'd0);
      queue_req(KIND_RESEED, 10'($urandom_range(0, 1023)), $urandom());
      for (int n = 0; n < 250; n++) queue_mixed();
      wait_idle();
    end

    $display("tb: %0d draws checked, %0d regenerations, %0d reseeds, %0d loads, %0d ignored",
             draws_done, twists_done, reseeds_done, loads_done, ignored_done);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/core/mtg_pkg.sv
rtl/core/mtg_datapath.sv
rtl/core/mtg_ctrl.sv
rtl/core/mersenne_twister_generator.sv
dv/mersenne_twister_generator_test.sv
